// ===== hw/rtl/rctadc_pkg.sv =====
// Shared types and constants for the RC charge-time ADC sequencer.
// Used by rctadc_core and rc_charge_time_adc_sequencer_top; no dependencies.

package rctadc_pkg;

   // Default sizing, handed down as module parameters
   localparam int MAX_CHANNELS_DEF = 8;
   localparam int TIME_BITS_DEF    = 32;

   // Fixed field widths of the channels
   localparam int LEVEL_W  = 8;
   localparam int NOW_W    = 32;
   localparam int ACTIVE_W = 4;
   localparam int RCH_W    = 3;
   localparam int RTIME_W  = 32;

   // Counter width for channel count compares (covers up to 63 channels)
   localparam int CNT_W = 6;

   // Reset value of the active channel count
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

   // Sequencer phase, one-hot
   typedef enum logic [2:0] {
      PH_IDLE      = 3'b001,
      PH_DISCHARGE = 3'b010,
      PH_CHARGE    = 3'b100
   } phase_type;

   // One result item
   typedef struct packed {
      logic               discharge_drive;
      logic               sweep_ready;
      logic               reading_valid;
      logic [RCH_W-1:0]   reading_channel;
      logic [RTIME_W-1:0] reading_time;
   } result_type;

endpackage

// ===== hw/rtl/rctadc_core.sv =====
// Sequencer core: phase control, channel stepping and the per-channel start-time memory.
// Depends on rctadc_pkg.

module rctadc_core #(
   parameter int MAX_CHANNELS = rctadc_pkg::MAX_CHANNELS_DEF,
   parameter int TIME_BITS    = rctadc_pkg::TIME_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic [rctadc_pkg::LEVEL_W-1:0]       channel_levels,
   input  logic [rctadc_pkg::NOW_W-1:0]         now_us,
   input  logic                                 csr_wr_en,
   input  logic [rctadc_pkg::ACTIVE_W-1:0]      csr_wr_data,
   output rctadc_pkg::result_type               result
);

   localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W = rctadc_pkg::CNT_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHANNELS);
   localparam logic [CNT_W-1:0] LEVEL_CNT = CNT_W'(rctadc_pkg::LEVEL_W);

   rctadc_pkg::phase_type phase_ff, phase_in;
   logic [CH_W-1:0]       ch_ff, ch_in;
   logic [rctadc_pkg::ACTIVE_W-1:0] active_ff;

   // Start-time memory, one entry per channel, registered read
   logic [TIME_BITS-1:0]  start_mem [MAX_CHANNELS];
   logic [TIME_BITS-1:0]  start_rd_ff;

   logic [CNT_W-1:0]      ch_ext;
   logic [CNT_W-1:0]      active_ext;
   logic [CNT_W-1:0]      sweep_len;
   logic                  level;
   logic                  last_ch;
   logic [TIME_BITS-1:0]  now_t;
   logic [TIME_BITS-1:0]  elapsed;
   logic                  start_wr;
   logic                  done;

   // Channel level lookup and sweep length clamp
   always_comb begin
      ch_ext     = CNT_W'(ch_ff);
      active_ext = CNT_W'(active_ff);
      level      = (ch_ext < LEVEL_CNT) ? channel_levels[ch_ext[2:0]] : 1'b0;
      if (active_ext == '0) begin
         sweep_len = CNT_W'(1);
      end else if (active_ext > MAX_CNT) begin
         sweep_len = MAX_CNT;
      end else begin
         sweep_len = active_ext;
      end
      last_ch = (ch_ext + CNT_W'(1)) >= sweep_len;
      now_t   = TIME_BITS'(now_us);
      elapsed = now_t - start_rd_ff;
   end

   // Next phase and channel
   always_comb begin
      phase_in = phase_ff;
      ch_in    = ch_ff;
      start_wr = 1'b0;
      done     = 1'b0;
      if (step) begin
         case (phase_ff)
            rctadc_pkg::PH_DISCHARGE: begin
               if (!level) begin
                  start_wr = 1'b1;
                  phase_in = rctadc_pkg::PH_CHARGE;
               end
            end
            rctadc_pkg::PH_CHARGE: begin
               if (level) begin
                  done = 1'b1;
                  if (last_ch) begin
                     ch_in    = '0;
                     phase_in = rctadc_pkg::PH_IDLE;
                  end else begin
                     ch_in    = CH_W'(ch_ext + CNT_W'(1));
                     phase_in = rctadc_pkg::PH_DISCHARGE;
                  end
               end
            end
            default: begin
               phase_in = rctadc_pkg::PH_DISCHARGE;
            end
         endcase
      end
   end

   // Result of this step
   always_comb begin
      result.discharge_drive = (phase_in == rctadc_pkg::PH_DISCHARGE);
      result.sweep_ready     = (phase_in == rctadc_pkg::PH_IDLE);
      result.reading_valid   = done;
      result.reading_channel = done ? ch_ext[rctadc_pkg::RCH_W-1:0] : '0;
      result.reading_time    = done ? rctadc_pkg::RTIME_W'(elapsed) : '0;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= rctadc_pkg::PH_IDLE;
         ch_ff     <= '0;
         active_ff <= rctadc_pkg::ACTIVE_RESET;
      end else begin
         phase_ff <= phase_in;
         ch_ff    <= ch_in;
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
      end
   end

   // Write start time; read the entry of the next channel, forward a same-entry write
   always_ff @(posedge clock) begin
      if (start_wr) begin
         start_mem[ch_ff] <= now_t;
      end
      if (start_wr && (ch_in == ch_ff)) begin
         start_rd_ff <= now_t;
      end else begin
         start_rd_ff <= start_mem[ch_in];
      end
   end

endmodule

// ===== hw/rtl/rc_charge_time_adc_sequencer_top.sv =====
// Top level of the RC charge-time ADC sequencer: configuration register port,
// input channel, sequencer core and a two-entry output buffer. Depends on rctadc_pkg, rctadc_core.
//
// Usage:
//  - req_ channel: one transfer per update step, carrying the comparator levels of all
//    channels and the free-running microsecond timestamp.
//  - rsp_ channel: exactly one result transfer per request transfer, in order: discharge
//    drive, sweep ready, and the completed reading (channel and charge time) if any.
//  - csr_ port: csr_wr_en writes the active channel count at any edge; a step taken at
//    that same edge still uses the old count.
// Output: rsp_ is driven from the output register, fed from the skid register under rsp_stall.
// Throughput: one request per cycle while req_stall is low; phase, channel index and start-time
//  memory update in the same cycle and the start-time read registers for the next step.
// Reset (synchronous): phase idle, channel 0, active count 8, output buffer empty.
//  Start-time entries are written before they are read, so they are not cleared.
// Receiver stall: results collect in the output register and a skid register;
//  req_stall rises only once both are full and falls when the skid entry drains.

module rc_charge_time_adc_sequencer_top #(
   parameter int MAX_CHANNELS = rctadc_pkg::MAX_CHANNELS_DEF,
   parameter int TIME_BITS    = rctadc_pkg::TIME_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [rctadc_pkg::LEVEL_W-1:0]     req_channel_levels,
   input  logic [rctadc_pkg::NOW_W-1:0]       req_now_us,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_discharge_drive,
   output logic                               rsp_sweep_ready,
   output logic                               rsp_reading_valid,
   output logic [rctadc_pkg::RCH_W-1:0]       rsp_reading_channel,
   output logic [rctadc_pkg::RTIME_W-1:0]     rsp_reading_time,
   input  logic                               csr_wr_en,
   input  logic [rctadc_pkg::ACTIVE_W-1:0]    csr_wr_data
);

   logic                   req_xfer;
   logic                   rsp_xfer;
   rctadc_pkg::result_type core_result;
   rctadc_pkg::result_type out_ff, out_in;
   rctadc_pkg::result_type skid_ff, skid_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;

   assign req_stall = skid_valid_ff;
   assign req_xfer  = req_valid && !skid_valid_ff;
   assign rsp_xfer  = out_valid_ff && !rsp_stall;

   rctadc_core #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .TIME_BITS    (TIME_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (req_xfer),
      .channel_levels (req_channel_levels),
      .now_us         (req_now_us),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .result         (core_result)
   );

   // Output buffer: drain skid first, park new results in skid when output is held
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_xfer) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = core_result;
            out_valid_in = req_xfer;
         end
      end else if (req_xfer) begin
         if (out_valid_ff) begin
            skid_in       = core_result;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = core_result;
            out_valid_in = 1'b1;
         end
      end
   end

   // Buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Buffer payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_discharge_drive = out_ff.discharge_drive;
   assign rsp_sweep_ready     = out_ff.sweep_ready;
   assign rsp_reading_valid   = out_ff.reading_valid;
   assign rsp_reading_channel = out_ff.reading_channel;
   assign rsp_reading_time    = out_ff.reading_time;

endmodule
